@@ design/noncrossing_matching_uncross_unit_macros.svh @@
// assertion macros for the noncrossing matching uncross unit
// no dependencies; included by the modules that assert
`ifndef NONCROSSING_MATCHING_UNCROSS_UNIT_MACROS_SVH
`define NONCROSSING_MATCHING_UNCROSS_UNIT_MACROS_SVH
`ifndef SYNTH
`define NMU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NMU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NMU_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define NMU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/nmu_pkg.sv @@
// shared constants, types and side test for the uncross unit
// no dependencies
package nmu_pkg;
  localparam int MAX_PAIRS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS = $clog2(MAX_PAIRS);
  localparam int CNT_BITS = IDX_BITS + 1;
  localparam int CFG_BITS = 7;
  localparam int OUT_IDX_BITS = 6;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_BITS-1:0] idx_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  // datapath commands
  typedef struct packed {
    logic store_pt;    // write input point at load address
    logic is_blue;
    idx_t load_addr;
    logic init_match;  // write identity at init address
    idx_t init_addr;
    logic fetch;       // read points of pair (j,k)
    logic fetch_blue;  // read blue ends of the fetched matches
    logic eval;        // compute side products
    logic apply;       // decide and swap
    idx_t j;
    idx_t k;
    logic rd_out;      // read match at j for output
  } nmu_cmd_t;

  typedef struct packed {
    logic crossed;     // last apply did a swap
    idx_t match_out;
  } nmu_stat_t;

  function automatic logic [1:0] sign_of(input logic signed [CROSS_BITS-1:0] c);
    sign_of = {c[CROSS_BITS-1], (c != '0) && !c[CROSS_BITS-1]};
  endfunction
endpackage

@@ design/nmu_if.sv @@
// valid/ready channel interfaces for the uncross unit
// depends on nmu_pkg
interface nmu_pt_if;
  logic valid;
  logic ready;
  nmu_pkg::coord_t coord_x;
  nmu_pkg::coord_t coord_y;
  modport source (output valid, coord_x, coord_y, input ready);
  modport sink (input valid, coord_x, coord_y, output ready);
endinterface

interface nmu_res_if;
  logic valid;
  logic ready;
  logic [nmu_pkg::OUT_IDX_BITS-1:0] red_index;
  logic [nmu_pkg::OUT_IDX_BITS-1:0] blue_index;
  logic last_pair;
  modport source (output valid, red_index, blue_index, last_pair, input ready);
  modport sink (input valid, red_index, blue_index, last_pair, output ready);
endinterface

interface nmu_cfg_if;
  logic valid;
  logic ready;
  logic [nmu_pkg::CFG_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ design/nmu_datapath.sv @@
// point memories, match table and crossing test
// depends on nmu_pkg
module nmu_datapath (
  input  logic              clk,
  input  nmu_pkg::nmu_cmd_t cmd,
  input  nmu_pkg::coord_t   in_x,
  input  nmu_pkg::coord_t   in_y,
  output nmu_pkg::nmu_stat_t stat
);
  localparam int DB = nmu_pkg::DIFF_BITS;
  localparam int PB = nmu_pkg::PROD_BITS;
  localparam int CB = nmu_pkg::CROSS_BITS;

  nmu_pkg::coord_t rx_mem [nmu_pkg::MAX_PAIRS];
  nmu_pkg::coord_t ry_mem [nmu_pkg::MAX_PAIRS];
  nmu_pkg::coord_t bx_mem [nmu_pkg::MAX_PAIRS];
  nmu_pkg::coord_t by_mem [nmu_pkg::MAX_PAIRS];
  nmu_pkg::idx_t match [nmu_pkg::MAX_PAIRS];

  nmu_pkg::coord_t ajx, ajy, akx, aky, bjx, bjy, bkx, bky;
  nmu_pkg::idx_t mj, mk;
  logic signed [PB-1:0] p [8];
  logic signed [DB-1:0] d [8];
  logic crossed;
  nmu_pkg::idx_t match_out;
  logic [1:0] s1, s2, s3, s4;
  logic do_swap;

  // match table: identity fill or swap, never both in one cycle
  always_ff @(posedge clk) begin
    if (cmd.init_match) begin
      match[cmd.init_addr] <= cmd.init_addr;
    end else if (cmd.apply && do_swap) begin
      match[cmd.j] <= mk;
      match[cmd.k] <= mj;
    end
    if (cmd.store_pt) begin
      if (cmd.is_blue) begin
        bx_mem[cmd.load_addr] <= in_x;
        by_mem[cmd.load_addr] <= in_y;
      end else begin
        rx_mem[cmd.load_addr] <= in_x;
        ry_mem[cmd.load_addr] <= in_y;
      end
    end
  end

  // fetch: read match pair
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      mj <= match[cmd.j];
      mk <= match[cmd.k];
      ajx <= rx_mem[cmd.j];
      ajy <= ry_mem[cmd.j];
      akx <= rx_mem[cmd.k];
      aky <= ry_mem[cmd.k];
    end
    if (cmd.rd_out) match_out <= match[cmd.j];
  end

  // blue points read once the registered matches are known
  always_ff @(posedge clk) begin
    if (cmd.fetch_blue) begin
      bjx <= bx_mem[mj];
      bjy <= by_mem[mj];
      bkx <= bx_mem[mk];
      bky <= by_mem[mk];
    end
  end

  always_comb begin
    d[0] = DB'(bjx) - DB'(ajx); d[1] = DB'(aky) - DB'(ajy);
    d[2] = DB'(bjy) - DB'(ajy); d[3] = DB'(akx) - DB'(ajx);
    d[4] = DB'(bkx) - DB'(akx); d[5] = DB'(ajy) - DB'(aky);
    d[6] = DB'(bky) - DB'(aky); d[7] = DB'(ajx) - DB'(akx);
  end

  logic signed [DB-1:0] e [8];
  always_comb begin
    e[0] = d[0]; e[1] = DB'(bky) - DB'(ajy);
    e[2] = d[2]; e[3] = DB'(bkx) - DB'(ajx);
    e[4] = d[4]; e[5] = DB'(bjy) - DB'(aky);
    e[6] = d[6]; e[7] = DB'(bjx) - DB'(akx);
  end

  // eval: eight products, registered
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      p[0] <= d[0] * d[1]; p[1] <= d[2] * d[3];
      p[2] <= e[0] * e[1]; p[3] <= e[2] * e[3];
      p[4] <= d[4] * d[5]; p[5] <= d[6] * d[7];
      p[6] <= e[4] * e[5]; p[7] <= e[6] * e[7];
    end
  end

  always_comb begin
    s1 = nmu_pkg::sign_of(CB'(p[0]) - CB'(p[1]));
    s2 = nmu_pkg::sign_of(CB'(p[2]) - CB'(p[3]));
    s3 = nmu_pkg::sign_of(CB'(p[4]) - CB'(p[5]));
    s4 = nmu_pkg::sign_of(CB'(p[6]) - CB'(p[7]));
    // strict opposite: one positive one negative
    do_swap = ((s1[0] && s2[1]) || (s1[1] && s2[0])) &&
              ((s3[0] && s4[1]) || (s3[1] && s4[0]));
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) crossed <= do_swap;
  end

  assign stat.crossed = crossed;
  assign stat.match_out = match_out;
endmodule

@@ design/nmu_ctrl.sv @@
// sequencer for load, uncross passes and result output
// depends on nmu_pkg and the assertion macro header
`include "noncrossing_matching_uncross_unit_macros.svh"
module nmu_ctrl (
  input  logic clk,
  input  logic rst,
  nmu_cfg_if.sink cfg,
  nmu_pt_if.sink  pt,
  nmu_res_if.source res,
  output nmu_pkg::nmu_cmd_t cmd,
  input  nmu_pkg::nmu_stat_t stat
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_APPLY = 4'd4;
  localparam logic [3:0] S_NEXT  = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_BLUE  = 4'd8;

  localparam int CB = nmu_pkg::CNT_BITS;
  localparam int IB = nmu_pkg::IDX_BITS;

  logic [3:0] state;
  logic [nmu_pkg::CFG_BITS-1:0] pair_count;
  nmu_pkg::cnt_t n, load_count, j, k;
  logic swapped;
  logic pt_acc, res_acc;

  always_comb begin
    if (pair_count == '0) n = CB'(1);
    else if (32'(pair_count) > nmu_pkg::MAX_PAIRS) n = CB'(nmu_pkg::MAX_PAIRS);
    else n = CB'(pair_count);
  end

  assign cfg.ready = (state == S_LOAD);
  assign pt.ready = (state == S_LOAD) && !cfg.valid;
  assign pt_acc = pt.valid && pt.ready;
  assign res.valid = (state == S_OUT);
  assign res_acc = res.valid && res.ready;
  assign res.red_index = nmu_pkg::OUT_IDX_BITS'(j[IB-1:0]);
  assign res.blue_index = nmu_pkg::OUT_IDX_BITS'(stat.match_out);
  assign res.last_pair = (j + CB'(1) == n);

  always_comb begin
    cmd = '0;
    cmd.store_pt = pt_acc;
    cmd.is_blue = (load_count >= n);
    cmd.load_addr = (load_count >= n) ? IB'(load_count - n) : load_count[IB-1:0];
    cmd.init_match = (state == S_INIT);
    cmd.init_addr = j[IB-1:0];
    cmd.fetch = (state == S_FETCH);
    cmd.fetch_blue = (state == S_BLUE);
    cmd.eval = (state == S_EVAL);
    cmd.apply = (state == S_APPLY);
    cmd.j = j[IB-1:0];
    cmd.k = k[IB-1:0];
    cmd.rd_out = (state == S_RD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      pair_count <= nmu_pkg::CFG_BITS'(1);
      load_count <= '0;
      j <= '0;
      k <= '0;
      swapped <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (cfg.valid) begin
            pair_count <= cfg.data;
            load_count <= '0;
          end else if (pt_acc) begin
            if (load_count + CB'(1) == (n << 1)) begin
              load_count <= '0;
              j <= '0;
              state <= S_INIT;
            end else begin
              load_count <= load_count + CB'(1);
            end
          end
        end
        S_INIT: begin
          if (j + CB'(1) == n) begin
            swapped <= 1'b0;
            j <= '0;
            k <= CB'(1);
            state <= (n == CB'(1)) ? S_RD : S_FETCH;
          end else begin
            j <= j + CB'(1);
          end
        end
        S_FETCH: state <= S_BLUE;
        S_BLUE:  state <= S_EVAL;
        S_EVAL:  state <= S_APPLY;
        S_APPLY: state <= S_NEXT;
        S_NEXT: begin
          if (k + CB'(1) < n) begin
            swapped <= swapped || stat.crossed;
            k <= k + CB'(1);
            state <= S_FETCH;
          end else if (j + CB'(2) < n) begin
            swapped <= swapped || stat.crossed;
            j <= j + CB'(1);
            k <= j + CB'(2);
            state <= S_FETCH;
          end else if (swapped || stat.crossed) begin
            swapped <= 1'b0;
            j <= '0;
            k <= CB'(1);
            state <= S_FETCH;
          end else begin
            j <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_OUT;
        S_OUT: begin
          if (res_acc) begin
            if (j + CB'(1) == n) begin
              j <= '0;
              state <= S_LOAD;
            end else begin
              j <= j + CB'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `NMU_ASSERT_IMPL(a_out_idle, clk, rst, res.valid, !pt.ready)
  `NMU_ASSERT_IMPL(a_k_gt_j, clk, rst, state == S_FETCH, (k > j) && (k < n))
  `NMU_ASSERT_NEXT(a_last_back, clk, rst, res_acc && res.last_pair, state == S_LOAD)
endmodule

@@ design/noncrossing_matching_uncross_unit.sv @@
// Loads n red points then n blue points, one per transaction, where n is pair_count
// clamped to 1..MAX_PAIRS; then repeats passes over all segment pairs (j<k), each pair
// test stepping through FETCH, BLUE, EVAL, APPLY and NEXT, swapping blue ends of strictly
// crossing segments until a pass has no swap; results then come out one at a time in red
// order, each read in RD and held in OUT until accepted. All pairs share one crossing test.
// depends on nmu_pkg, the interfaces, nmu_ctrl and nmu_datapath
module noncrossing_matching_uncross_unit (
  input logic clk,
  input logic rst,
  nmu_cfg_if.sink cfg,
  nmu_pt_if.sink pt,
  nmu_res_if.source res
);
  nmu_pkg::nmu_cmd_t cmd;
  nmu_pkg::nmu_stat_t stat;

  nmu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg(cfg), .pt(pt), .res(res), .cmd(cmd), .stat(stat)
  );

  nmu_datapath u_dp (
    .clk(clk), .cmd(cmd), .in_x(pt.coord_x), .in_y(pt.coord_y), .stat(stat)
  );
endmodule

@@ sim/tb_noncrossing_matching_uncross_unit.sv @@
// testbench for the noncrossing matching uncross unit: random points through valid/ready
// channels, expected matchings from an uncrossing predictor kept in the bench
// depends on nmu_pkg, the channel interfaces and noncrossing_matching_uncross_unit
`timescale 1ns / 100ps

module tb_noncrossing_matching_uncross_unit;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    nmu_pkg::coord_t x;
    nmu_pkg::coord_t y;
  } point_t;

  typedef struct packed {
    logic [nmu_pkg::OUT_IDX_BITS-1:0] red_index;
    logic [nmu_pkg::OUT_IDX_BITS-1:0] blue_index;
    logic last_pair;
  } pairing_t;

  logic clk;
  logic rst;

  nmu_cfg_if cfg ();
  nmu_pt_if pt ();
  nmu_res_if res ();

  noncrossing_matching_uncross_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .pt(pt),
    .res(res)
  );

  point_t point_q[$];
  pairing_t pairing_q[$];

  // predictor state
  logic [nmu_pkg::CFG_BITS-1:0] pairs_reg;
  longint red_px[nmu_pkg::MAX_PAIRS];
  longint red_py[nmu_pkg::MAX_PAIRS];
  longint blue_px[nmu_pkg::MAX_PAIRS];
  longint blue_py[nmu_pkg::MAX_PAIRS];
  int match_blue[nmu_pkg::MAX_PAIRS];
  int points_loaded;

  int errors;
  int points_sent;
  int pairings_seen;
  int batches_done;
  int cfg_writes;
  longint cycles;

  function automatic int active_pairs(input logic [nmu_pkg::CFG_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > nmu_pkg::MAX_PAIRS) return nmu_pkg::MAX_PAIRS;
    return int'(v);
  endfunction

  function automatic int side(input longint ax, ay, bx, by, px, py);
    longint c;
    c = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
  endfunction

  function automatic bit segments_cross(input int j, input int k);
    int bj, bk, s1, s2, s3, s4;
    bj = match_blue[j];
    bk = match_blue[k];
    s1 = side(red_px[j], red_py[j], blue_px[bj], blue_py[bj], red_px[k], red_py[k]);
    s2 = side(red_px[j], red_py[j], blue_px[bj], blue_py[bj], blue_px[bk], blue_py[bk]);
    s3 = side(red_px[k], red_py[k], blue_px[bk], blue_py[bk], red_px[j], red_py[j]);
    s4 = side(red_px[k], red_py[k], blue_px[bk], blue_py[bk], blue_px[bj], blue_py[bj]);
    return (s1 * s2 < 0) && (s3 * s4 < 0);
  endfunction

  // loads one point; on the last blue point runs the uncrossing and queues the pairing
  function automatic void load_point(input point_t p);
    int n, t;
    bit swapped;
    pairing_t r;
    n = active_pairs(pairs_reg);
    if (points_loaded < n) begin
      red_px[points_loaded] = p.x;
      red_py[points_loaded] = p.y;
    end else begin
      blue_px[points_loaded - n] = p.x;
      blue_py[points_loaded - n] = p.y;
    end
    points_loaded++;
    if (points_loaded < 2 * n) return;
    points_loaded = 0;
    for (int i = 0; i < n; i++) match_blue[i] = i;
    do begin
      swapped = 0;
      for (int j = 0; j < n; j++) begin
        for (int k = j + 1; k < n; k++) begin
          if (segments_cross(j, k)) begin
            swapped = 1;
            t = match_blue[j];
            match_blue[j] = match_blue[k];
            match_blue[k] = t;
          end
        end
      end
    end while (swapped);
    for (int i = 0; i < n; i++) begin
      r.red_index = i[nmu_pkg::OUT_IDX_BITS-1:0];
      r.blue_index = match_blue[i][nmu_pkg::OUT_IDX_BITS-1:0];
      r.last_pair = (i == n - 1);
      pairing_q.push_back(r);
    end
    batches_done++;
  endfunction

  function automatic int pick_gap(input bit burst);
    if (burst) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
    return $urandom_range(0, 3);
  endfunction

  initial begin
    clk = 0;
    rst = 1;
    cfg.valid = 0;
    cfg.data = '0;
    pt.valid = 0;
    pt.coord_x = '0;
    pt.coord_y = '0;
    res.ready = 0;
    forever #5 clk = ~clk;
  end

  // point driver
  int send_gap;
  bit send_burst;
  always @(posedge clk) begin
    if (rst) begin
      pt.valid <= 1'b0;
      send_gap <= 0;
      send_burst <= 0;
    end else if (pt.valid && !pt.ready) begin
      // hold the pending transaction
    end else if (send_gap > 0) begin
      pt.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (point_q.size() > 0) begin
      point_t p;
      p = point_q.pop_front();
      pt.valid <= 1'b1;
      pt.coord_x <= p.x;
      pt.coord_y <= p.y;
      if ($urandom_range(0, 49) == 0) send_burst <= ~send_burst;
      send_gap <= pick_gap(send_burst);
    end else begin
      pt.valid <= 1'b0;
    end
  end

  // result sink readiness
  int sink_gap;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      sink_gap <= 0;
    end else if (sink_gap > 0) begin
      res.ready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      res.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap <= pick_gap(0);
    end
  end

  // transaction monitor: feeds the predictor and checks results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        pairs_reg = cfg.data;
        points_loaded = 0;
        cfg_writes++;
      end
      if (pt.valid && pt.ready) begin
        point_t p;
        p.x = pt.coord_x;
        p.y = pt.coord_y;
        load_point(p);
        points_sent++;
      end
      if (res.valid && res.ready) begin
        pairing_t got, want;
        got.red_index = res.red_index;
        got.blue_index = res.blue_index;
        got.last_pair = res.last_pair;
        pairings_seen++;
        if (pairing_q.size() == 0) begin
          $display("%0t: unexpected result red=%0d blue=%0d last=%0d", $time,
                   got.red_index, got.blue_index, got.last_pair);
          errors++;
        end else begin
          want = pairing_q.pop_front();
          if (got.red_index !== want.red_index)
            $display("%0t: red_index expected %0d actual %0d", $time,
                     want.red_index, got.red_index);
          if (got.blue_index !== want.blue_index)
            $display("%0t: blue_index expected %0d actual %0d", $time,
                     want.blue_index, got.blue_index);
          if (got.last_pair !== want.last_pair)
            $display("%0t: last_pair expected %0d actual %0d", $time,
                     want.last_pair, got.last_pair);
          if (got !== want) errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    wait (point_q.size() == 0);
    while (pt.valid || pairing_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pairs(input int v);
    wait_idle();
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v[nmu_pkg::CFG_BITS-1:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic add_point(input int x, input int y);
    point_t p;
    p.x = x[nmu_pkg::COORD_BITS-1:0];
    p.y = y[nmu_pkg::COORD_BITS-1:0];
    point_q.push_back(p);
  endtask

  task automatic random_batch(input int n, input bit tight);
    for (int i = 0; i < 2 * n; i++) begin
      if (tight) add_point($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
      else add_point($urandom, $urandom);
    end
  endtask

  int n;
  initial begin
    errors = 0;
    points_sent = 0;
    pairings_seen = 0;
    batches_done = 0;
    cfg_writes = 0;
    cycles = 0;
    pairs_reg = 1;
    points_loaded = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // single pair at the default count, at the corners of the range
    add_point(-32768, -32768);
    add_point(32767, 32767);
    // zero count acts as one pair
    write_pairs(0);
    add_point(32767, -32768);
    add_point(-32768, 32767);
    // two crossing segments get swapped
    write_pairs(2);
    add_point(-1, -1);
    add_point(-1, 1);
    add_point(1, 1);
    add_point(1, -1);
    // full-range crossing, exercises wide products
    add_point(-32768, -32768);
    add_point(-32768, 32767);
    add_point(32767, 32767);
    add_point(32767, -32768);
    // end point touching the other segment is no crossing
    add_point(0, 0);
    add_point(-2, 2);
    add_point(2, 0);
    add_point(2, -2);
    // collinear overlap is no crossing
    add_point(0, 0);
    add_point(1, 0);
    add_point(2, 0);
    add_point(3, 0);
    // partial load dropped by a register write
    add_point(5, 5);
    add_point(6, 6);
    write_pairs(3);
    random_batch(3, 0);

    // random batches, mostly small sizes
    while (points_sent + point_q.size() < 110) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 8);
      write_pairs(n);
      repeat ($urandom_range(1, 3)) random_batch(n, $urandom_range(0, 2) == 0);
    end
    // one batch at the saturated maximum
    write_pairs(127);
    random_batch(nmu_pkg::MAX_PAIRS, 0);
    write_pairs(8);
    random_batch(8, 1);

    wait_idle();
    $display("ran %0d points in %0d batches over %0d register writes", points_sent,
             batches_done, cfg_writes);
    $display("checked %0d pairings, sizes from one pair up to %0d", pairings_seen,
             nmu_pkg::MAX_PAIRS);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+design
design/nmu_pkg.sv
design/nmu_if.sv
design/nmu_datapath.sv
design/nmu_ctrl.sv
design/noncrossing_matching_uncross_unit.sv
sim/tb_noncrossing_matching_uncross_unit.sv
